@@ hw/rtl/dbc_pkg.sv @@
// ----------------------------------------------------------------------------
// dbc_pkg
// Types and constants shared by the button debounce and click detector.
// ----------------------------------------------------------------------------
package dbc_pkg;

   // Button count and widths follow from the fixed field widths of the ports
   localparam int BUTTONS = 3;
   localparam int IDX_W   = 2;
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;

   // Event codes on the result channel
   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_DOUBLE  = 2'd2,
      EV_SINGLE  = 2'd3
   } evt_code_type;

   // Configuration register indexes (index 3 is unused and ignored)
   typedef enum logic [1:0] {
      CSR_DEBOUNCE      = 2'd0,
      CSR_DOUBLE_CLICK  = 2'd1,
      CSR_ACTIVE_LEVELS = 2'd2
   } csr_index_type;

   // Per-button state entry kept in the state memory
   typedef struct packed {
      logic              tracked;
      logic              stable;
      logic [TIME_W-1:0] change_time;
      logic [1:0]        tap_count;
      logic [TIME_W-1:0] release_time;
   } btn_state_type;

   // One event on its way to the result channel
   typedef struct packed {
      logic [IDX_W-1:0]  button;
      evt_code_type      code;
      logic [TIME_W-1:0] time_ms;
   } evt_type;

   // Engine to event queue control
   typedef struct packed {
      logic push;
      logic flush;
   } evq_ctrl_type;

   // Configuration register set
   typedef struct packed {
      logic [CFG_W-1:0]   debounce_ms;
      logic [CFG_W-1:0]   double_click_ms;
      logic [BUTTONS-1:0] active_levels;
   } cfg_type;

endpackage

@@ hw/rtl/dbc_state_mem.sv @@
// ----------------------------------------------------------------------------
// dbc_state_mem
// Per-button state memory: one write port, one read port, registered read
// data. Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module dbc_state_mem
   import dbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output btn_state_type    rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  btn_state_type    wr_data
);

   btn_state_type      mem [0:BUTTONS-1];
   btn_state_type      rd_data_ff;
   logic               rd_vld_ff;
   logic [BUTTONS-1:0] vld_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ hw/rtl/dbc_evt_out.sv @@
// ----------------------------------------------------------------------------
// dbc_evt_out
// Event queue to the result channel. The newest event is held back one slot
// so that the final event of a poll can be marked when the engine flushes.
// ----------------------------------------------------------------------------
module dbc_evt_out
   import dbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  evq_ctrl_type      ctrl,
   input  evt_type           evt,
   output logic              evq_ready,
   output logic              evq_pending,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [IDX_W-1:0]  rsp_button_index,
   output logic [1:0]        rsp_event_code,
   output logic [TIME_W-1:0] rsp_event_time,
   output logic              rsp_last_of_run
);

   evt_type held_ff;
   logic    held_vld_ff;
   evt_type out_ff;
   logic    out_last_ff;
   logic    out_vld_ff;

   logic    out_free;
   logic    push_go;
   logic    flush_go;
   logic    load_out;

   // Held slot may move on when the output register is empty or being taken
   assign out_free  = !out_vld_ff || rsp_ready;
   assign evq_ready = !held_vld_ff || out_free;
   assign push_go   = ctrl.push && evq_ready;
   assign flush_go  = ctrl.flush && evq_ready;
   assign load_out  = held_vld_ff && (push_go || flush_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         // Output register: loaded from the held slot, or emptied when taken
         if (load_out) begin
            out_ff      <= held_ff;
            out_last_ff <= !push_go;
            out_vld_ff  <= 1'b1;
         end else if (out_vld_ff && rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         // Held slot: refilled on push, emptied on flush
         if (push_go) begin
            held_ff     <= evt;
            held_vld_ff <= 1'b1;
         end else if (flush_go) begin
            held_vld_ff <= 1'b0;
         end
      end
   end

   assign evq_pending      = held_vld_ff;
   assign rsp_valid        = out_vld_ff;
   assign rsp_button_index = out_ff.button;
   assign rsp_event_code   = out_ff.code;
   assign rsp_event_time   = out_ff.time_ms;
   assign rsp_last_of_run  = out_last_ff;

endmodule

@@ hw/rtl/dbc_engine.sv @@
// ----------------------------------------------------------------------------
// dbc_engine
// Poll sequencer: two passes over the buttons, each a read of the button's
// state entry, an update with write-back, and the push of its events.
// ----------------------------------------------------------------------------
module dbc_engine
   import dbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TIME_W-1:0]  req_now_ms,
   input  logic [BUTTONS-1:0] req_raw_levels,
   input  cfg_type            cfg,
   output logic               mem_rd_en,
   output logic [IDX_W-1:0]   mem_rd_addr,
   input  btn_state_type      mem_rd_data,
   output logic               mem_wr_en,
   output logic [IDX_W-1:0]   mem_wr_addr,
   output btn_state_type      mem_wr_data,
   output evq_ctrl_type       evq_ctrl,
   output evt_type            evq_evt,
   input  logic               evq_ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTONS - 1);

   state_type          state_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [BUTTONS-1:0] raw_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               pass_ff;
   evt_type            ev0_ff;
   evt_type            ev1_ff;
   logic               ev_two_ff;
   logic               ev_sel_ff;

   btn_state_type      st_in;
   logic [1:0]         ev_cnt;
   evt_code_type       ev0_code;
   logic [TIME_W-1:0]  ev0_time;
   logic               pressed;
   logic               changed;
   logic [TIME_W-1:0]  held_ms;
   logic [TIME_W-1:0]  rel_gap;
   logic [1:0]         clicks;
   logic               rel_close;

   // Button update for the entry just read
   always_comb begin
      st_in    = mem_rd_data;
      ev_cnt   = 2'd0;
      ev0_code = EV_PRESS;
      ev0_time = now_ff;
      pressed  = ~(raw_ff[idx_ff] ^ cfg.active_levels[idx_ff]);
      changed  = pressed != mem_rd_data.tracked;
      held_ms  = changed ? '0 : now_ff - mem_rd_data.change_time;
      rel_gap  = now_ff - mem_rd_data.release_time;
      rel_close = rel_gap <= {{(TIME_W-CFG_W){1'b0}}, cfg.double_click_ms};
      clicks   = mem_rd_data.tap_count + 2'd1;
      if (!pass_ff) begin
         if (changed) begin
            st_in.tracked     = pressed;
            st_in.change_time = now_ff;
         end
         if (held_ms >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms} &&
             st_in.tracked != mem_rd_data.stable) begin
            st_in.stable = st_in.tracked;
            ev_cnt       = 2'd1;
            if (st_in.tracked) begin
               ev0_code = EV_PRESS;
            end else begin
               ev0_code           = EV_RELEASE;
               st_in.release_time = now_ff;
               if (rel_close) begin
                  if (clicks == 2'd2) begin
                     st_in.tap_count = 2'd0;
                     ev_cnt          = 2'd2;
                  end else begin
                     st_in.tap_count = clicks;
                  end
               end else begin
                  st_in.tap_count = 2'd1;
               end
            end
         end
      end else begin
         // Pending single click once the window has passed
         if (mem_rd_data.tap_count == 2'd1 && !rel_close) begin
            st_in.tap_count = 2'd0;
            ev_cnt          = 2'd1;
            ev0_code        = EV_SINGLE;
            ev0_time        = mem_rd_data.release_time;
         end
      end
   end

   assign req_ready      = state_ff == ST_IDLE;
   assign mem_rd_en      = state_ff == ST_READ;
   assign mem_rd_addr    = idx_ff;
   assign mem_wr_en      = state_ff == ST_EVAL;
   assign mem_wr_addr    = idx_ff;
   assign mem_wr_data    = st_in;
   assign evq_ctrl.push  = state_ff == ST_EMIT;
   assign evq_ctrl.flush = state_ff == ST_FLUSH;
   assign evq_evt        = ev_sel_ff ? ev1_ff : ev0_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         pass_ff   <= 1'b0;
         ev_sel_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  now_ff   <= req_now_ms;
                  raw_ff   <= req_raw_levels;
                  idx_ff   <= '0;
                  pass_ff  <= 1'b0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               ev0_ff    <= '{button: idx_ff, code: ev0_code, time_ms: ev0_time};
               ev1_ff    <= '{button: idx_ff, code: EV_DOUBLE, time_ms: now_ff};
               ev_two_ff <= ev_cnt == 2'd2;
               ev_sel_ff <= 1'b0;
               if (ev_cnt != 2'd0) begin
                  state_ff <= ST_EMIT;
               end else if (idx_ff != LAST_IDX) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_READ;
               end else if (!pass_ff) begin
                  idx_ff   <= '0;
                  pass_ff  <= 1'b1;
                  state_ff <= ST_READ;
               end else begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_EMIT: begin
               if (evq_ready) begin
                  if (!ev_sel_ff && ev_two_ff) begin
                     ev_sel_ff <= 1'b1;
                  end else if (idx_ff != LAST_IDX) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_READ;
                  end else if (!pass_ff) begin
                     idx_ff   <= '0;
                     pass_ff  <= 1'b1;
                     state_ff <= ST_READ;
                  end else begin
                     state_ff <= ST_FLUSH;
                  end
               end
            end
            ST_FLUSH: begin
               if (evq_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/button_debounce_click_detector.sv @@
// ----------------------------------------------------------------------------
// button_debounce_click_detector
// Debounced press/release events with single and double click detection.
// ----------------------------------------------------------------------------
// Each request is one poll: a 32-bit millisecond time and the raw pin levels
// of three buttons. The block answers with zero to six events (press,
// release, double click, single click), the last one flagged by
// rsp_last_of_run; a poll with no event produces nothing. Button state lives
// in a small state memory that is read, updated and written back once per
// button in each of two passes (edges first, then pending single clicks).
// One request is handled at a time: req_ready returns only after both passes,
// in which each button gets a read state and an update state, plus an emit
// state per event, and the final flush of the event queue. Configuration
// writes (debounce time, double click window, active levels) are always
// accepted and should be made while no poll is in flight.
// ----------------------------------------------------------------------------
module button_debounce_click_detector
   import dbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TIME_W-1:0]  req_now_ms,
   input  logic [BUTTONS-1:0] req_raw_levels,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IDX_W-1:0]   rsp_button_index,
   output logic [1:0]         rsp_event_code,
   output logic [TIME_W-1:0]  rsp_event_time,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [CFG_W-1:0]   csr_data
);

   cfg_type       cfg_ff;
   logic          mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   btn_state_type mem_rd_data;
   logic          mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   btn_state_type mem_wr_data;
   evq_ctrl_type  evq_ctrl;
   evt_type       evq_evt;
   logic          evq_ready;
   logic          evq_pending;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= CFG_W'(20);
         cfg_ff.double_click_ms <= CFG_W'(300);
         cfg_ff.active_levels   <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE:      cfg_ff.debounce_ms     <= csr_data;
            CSR_DOUBLE_CLICK:  cfg_ff.double_click_ms <= csr_data;
            CSR_ACTIVE_LEVELS: cfg_ff.active_levels   <= csr_data[BUTTONS-1:0];
            default: begin
            end
         endcase
      end
   end

   dbc_state_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   dbc_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_now_ms     (req_now_ms),
      .req_raw_levels (req_raw_levels),
      .cfg            (cfg_ff),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .evq_ctrl       (evq_ctrl),
      .evq_evt        (evq_evt),
      .evq_ready      (evq_ready)
   );

   dbc_evt_out u_evt_out (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (evq_ctrl),
      .evt              (evq_evt),
      .evq_ready        (evq_ready),
      .evq_pending      (evq_pending),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_button_index (rsp_button_index),
      .rsp_event_code   (rsp_event_code),
      .rsp_event_time   (rsp_event_time),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // One poll at a time: no new request right after one is taken
   a_one_poll: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a poll is in flight");

   // Every held event is flushed before the next poll is taken
   a_no_stale_event: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !evq_pending)
      else $error("event left pending across polls");

   // Events only name existing buttons
   a_button_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_button_index <= IDX_W'(BUTTONS - 1)))
      else $error("event for a nonexistent button");

endmodule
